FILE: rtl/key_value_map_table_core_defines.svh
// ----------------------------------------------------------------------------
// Key/value map table: assertion macros
// Shared property wrappers clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef KEY_VALUE_MAP_TABLE_CORE_DEFINES_SVH
`define KEY_VALUE_MAP_TABLE_CORE_DEFINES_SVH

// Same-cycle implication
`define KVMT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define KVMT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/kvmt_pkg.sv
// ----------------------------------------------------------------------------
// Key/value map table package
// Request codes, sequencer states and fixed field widths.
// ----------------------------------------------------------------------------
`default_nettype none

package kvmt_pkg;

  localparam int FIELD_W = 64;
  localparam int COUNT_W = 5;

  typedef enum logic [1:0] {
    REQ_SET    = 2'd0,
    REQ_LOOKUP = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EXEC,
    ST_RANK,
    ST_COPY,
    ST_DRAIN,
    ST_FLUSH
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/key_value_map_table_core.sv
// Lookup, overwrite, refused set, absent remove: scan pass, then exec; the result is registered from exec.
// Insert and remove: result registered from exec likewise, and busy stays high through the rank pass.
// Clear: scan pass; with release on and a nonempty table, then copy pass, drain pass and flush.
// Every pass walks the slot memory read port, one slot per cycle.
// Reset (rst, synchronous) empties the table at once through valid flip-flops.
// Results are one-cycle strobes; the receiver cannot stall them.
// ----------------------------------------------------------------------------
// Key/value map table core
// Fixed-capacity map of unique keys to values, scanned by a small sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module key_value_map_table_core #(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 64,
  parameter int VALUE_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cfg_write,
  input  logic                          cfg_data,
  input  logic [1:0]                    req_type,
  input  logic [kvmt_pkg::FIELD_W-1:0]  key,
  input  logic [kvmt_pkg::FIELD_W-1:0]  value,
  output logic                          result_strobe,
  output logic                          status,
  output logic                          found,
  output logic [kvmt_pkg::FIELD_W-1:0]  read_value,
  output logic                          released_valid,
  output logic [kvmt_pkg::FIELD_W-1:0]  released_value,
  output logic [kvmt_pkg::COUNT_W-1:0]  entry_count,
  output logic                          last
);

  import kvmt_pkg::*;

`include "key_value_map_table_core_defines.svh"

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  // storage
  logic [KEY_BITS-1:0]   key_mem  [ENTRIES];
  logic [VALUE_BITS-1:0] val_mem  [ENTRIES];
  logic [IDX_W-1:0]      rank_mem [ENTRIES];
  logic [VALUE_BITS-1:0] clr_mem  [ENTRIES];
  logic [ENTRIES-1:0]    slot_valid;
  logic [CNT_W-1:0]      held_count;
  logic [CNT_W-1:0]      held_next;
  logic                  release_en;

  // sequencer
  state_t           state, state_next;
  logic [CNT_W-1:0] cnt;
  logic [IDX_W-1:0] rd_addr;
  logic             in_pass;
  logic             pass_end;
  logic             pipe_v;
  logic [IDX_W-1:0] pipe_idx;

  // latched transaction
  req_t                  req_q;
  logic [KEY_BITS-1:0]   req_key;
  logic [VALUE_BITS-1:0] req_val;

  // registered memory reads
  logic [KEY_BITS-1:0]   mem_key;
  logic [VALUE_BITS-1:0] mem_val;
  logic [IDX_W-1:0]      mem_rank;
  logic                  mem_vld;
  logic [VALUE_BITS-1:0] clr_q;

  // scan results
  logic                  match_hit;
  logic [IDX_W-1:0]      match_idx;
  logic [VALUE_BITS-1:0] match_val;
  logic [IDX_W-1:0]      match_rank;
  logic                  free_hit;
  logic [IDX_W-1:0]      free_idx;
  logic                  full;

  // clear drain
  logic [CNT_W-1:0]      clr_n;
  logic                  pend_v;
  logic [VALUE_BITS-1:0] pend_val;
  logic                  drain_take;

  // result before the output register
  logic                  res_strobe;
  logic                  res_status;
  logic                  res_found;
  logic [VALUE_BITS-1:0] res_read;
  logic                  res_rel_v;
  logic [VALUE_BITS-1:0] res_rel;
  logic                  res_last;

  logic accept;
  logic do_insert;
  logic do_remove;
  logic clr_release;

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign in_pass   = state inside {ST_SCAN, ST_RANK, ST_COPY, ST_DRAIN};
  assign pass_end  = (cnt == CNT_W'(ENTRIES));
  assign rd_addr   = (in_pass && (cnt < CNT_W'(ENTRIES))) ? cnt[IDX_W-1:0] : '0;
  assign full      = (held_count == CNT_W'(ENTRIES));

  assign do_insert   = (req_q == REQ_SET) && !match_hit && !full;
  assign do_remove   = (req_q == REQ_REMOVE) && match_hit;
  assign clr_release = release_en && (held_count != '0);

  assign drain_take = (state == ST_DRAIN) && pipe_v &&
                      (CNT_W'(pipe_idx) < clr_n) && (clr_q != '0);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start) state_next = ST_SCAN;
      ST_SCAN:  if (pass_end) state_next = ST_EXEC;
      ST_EXEC: begin
        unique case (req_q)
          REQ_SET:    state_next = do_insert ? ST_RANK : ST_IDLE;
          REQ_LOOKUP: state_next = ST_IDLE;
          REQ_REMOVE: state_next = match_hit ? ST_RANK : ST_IDLE;
          REQ_CLEAR:  state_next = clr_release ? ST_COPY : ST_IDLE;
          default:    state_next = ST_IDLE;
        endcase
      end
      ST_RANK:  if (pass_end) state_next = ST_IDLE;
      ST_COPY:  if (pass_end) state_next = ST_DRAIN;
      ST_DRAIN: if (pass_end) state_next = ST_FLUSH;
      ST_FLUSH: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // result outputs
  always_comb begin
    res_strobe = 1'b0;
    res_status = 1'b0;
    res_found  = 1'b0;
    res_read   = '0;
    res_rel_v  = 1'b0;
    res_rel    = '0;
    res_last   = 1'b0;
    unique case (state)
      ST_EXEC: begin
        res_last   = 1'b1;
        res_strobe = 1'b1;
        case (req_q)
          REQ_SET: begin
            if (match_hit) begin
              res_found = 1'b1;
              res_rel_v = release_en && (match_val != '0) && (match_val != req_val);
              res_rel   = res_rel_v ? match_val : '0;
            end else if (full) begin
              res_status = 1'b1;
            end
          end
          REQ_LOOKUP, REQ_REMOVE: begin
            res_found = match_hit;
            res_read  = match_hit ? match_val : '0;
          end
          default: begin
            // clear with release on and a nonempty table reports from the drain and flush instead
            if (clr_release) begin
              res_strobe = 1'b0;
              res_last   = 1'b0;
            end
          end
        endcase
      end
      ST_DRAIN: begin
        if (drain_take && pend_v) begin
          res_strobe = 1'b1;
          res_rel_v  = 1'b1;
          res_rel    = pend_val;
        end
      end
      ST_FLUSH: begin
        res_strobe = 1'b1;
        res_last   = 1'b1;
        res_rel_v  = pend_v;
        res_rel    = pend_v ? pend_val : '0;
      end
      default: ;
    endcase
  end

  // count after the transaction
  always_comb begin
    held_next = held_count;
    if (state == ST_EXEC) begin
      if (do_insert) begin
        held_next = CNT_W'(held_count + 1'b1);
      end else if (do_remove) begin
        held_next = CNT_W'(held_count - 1'b1);
      end else if (req_q == REQ_CLEAR) begin
        held_next = '0;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      cnt           <= '0;
      pipe_v        <= 1'b0;
      slot_valid    <= '0;
      held_count    <= '0;
      release_en    <= 1'b0;
      match_hit     <= 1'b0;
      free_hit      <= 1'b0;
      pend_v        <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      held_count    <= held_next;
      result_strobe <= res_strobe;
      pipe_v        <= in_pass && (cnt < CNT_W'(ENTRIES));
      if (cfg_write) begin
        release_en <= cfg_data;
      end
      if (state != state_next) begin
        cnt <= '0;
      end else if (in_pass && !pass_end) begin
        cnt <= CNT_W'(cnt + 1'b1);
      end
      if (accept) begin
        match_hit <= 1'b0;
        free_hit  <= 1'b0;
      end else if ((state == ST_SCAN) && pipe_v) begin
        if (mem_vld && (mem_key == req_key)) begin
          match_hit <= 1'b1;
        end
        if (!mem_vld) begin
          free_hit <= 1'b1;
        end
      end
      if (state == ST_EXEC) begin
        pend_v <= 1'b0;
        if (do_insert) begin
          slot_valid[free_idx] <= 1'b1;
        end else if (do_remove) begin
          slot_valid[match_idx] <= 1'b0;
        end else if ((req_q == REQ_CLEAR) && !clr_release) begin
          slot_valid <= '0;
        end
      end
      if ((state == ST_COPY) && pass_end) begin
        slot_valid <= '0;
      end
      if (drain_take) begin
        pend_v <= 1'b1;
      end
    end
  end

  // payload, memories and output register
  always_ff @(posedge clk) begin
    if (accept) begin
      req_q   <= req_t'(req_type);
      req_key <= key[KEY_BITS-1:0];
      req_val <= value[VALUE_BITS-1:0];
    end

    mem_key  <= key_mem[rd_addr];
    mem_val  <= val_mem[rd_addr];
    mem_rank <= rank_mem[rd_addr];
    mem_vld  <= slot_valid[rd_addr];
    clr_q    <= clr_mem[rd_addr];
    pipe_idx <= rd_addr;

    if ((state == ST_SCAN) && pipe_v) begin
      if (mem_vld && (mem_key == req_key)) begin
        match_idx  <= pipe_idx;
        match_val  <= mem_val;
        match_rank <= mem_rank;
      end
      // keep the lowest free slot
      if (!mem_vld && !free_hit) begin
        free_idx <= pipe_idx;
      end
    end

    if (state == ST_EXEC) begin
      clr_n <= held_count;
      if (do_insert) begin
        key_mem[free_idx]  <= req_key;
        val_mem[free_idx]  <= req_val;
        rank_mem[free_idx] <= '0;
      end else if ((req_q == REQ_SET) && match_hit) begin
        val_mem[match_idx] <= req_val;
      end
    end

    // age the others on insert, close the gap on remove
    if ((state == ST_RANK) && pipe_v && mem_vld) begin
      if (req_q == REQ_REMOVE) begin
        if (mem_rank > match_rank) begin
          rank_mem[pipe_idx] <= IDX_W'(mem_rank - 1'b1);
        end
      end else if (pipe_idx != free_idx) begin
        rank_mem[pipe_idx] <= IDX_W'(mem_rank + 1'b1);
      end
    end

    // sort held values by age for the clear drain
    if ((state == ST_COPY) && pipe_v && mem_vld) begin
      clr_mem[mem_rank] <= mem_val;
    end

    if (drain_take) begin
      pend_val <= clr_q;
    end

    status         <= res_status;
    found          <= res_found;
    read_value     <= FIELD_W'(res_read);
    released_valid <= res_rel_v;
    released_value <= FIELD_W'(res_rel);
    entry_count    <= COUNT_W'(held_next);
    last           <= res_last;
  end

  `KVMT_ASSERT_IMP(a_count_range, 1'b1, held_count <= CNT_W'(ENTRIES), "entry count over capacity")
  `KVMT_ASSERT_IMP(a_valid_count, state == ST_IDLE, $countones(slot_valid) == int'(held_count), "valid bits disagree with count")
  `KVMT_ASSERT_NXT(a_accept_busy, accept, busy, "accepted transaction did not raise busy")
  `KVMT_ASSERT_IMP(a_release_strobe, released_valid, result_strobe, "release reported without strobe")
  `KVMT_ASSERT_IMP(a_refused_set, result_strobe && status, !found && !released_valid, "refused set reported a hit")

endmodule

`default_nettype wire

FILE: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Key/value map table core testbench
// Drives set, lookup, remove and clear requests under several settings of the
// release enable, with bursts of sender idling, and checks every result strobe
// against a shadow copy of the table kept in the bench.
// ----------------------------------------------------------------------------

module testbench;

  import kvmt_pkg::*;

  localparam int ENTRIES   = 16;
  localparam int KEY_POOL  = 24;
  localparam int LIMIT     = 200000;
  localparam int TAIL_WAIT = 3 * (ENTRIES + 1) + 8;

  typedef struct packed {
    logic               status;
    logic               found;
    logic [FIELD_W-1:0] read_value;
    logic               released_valid;
    logic [FIELD_W-1:0] released_value;
    logic [COUNT_W-1:0] entry_count;
    logic               last;
  } map_resp_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               start;
  logic               busy;
  logic               cfg_write;
  logic               cfg_data;
  logic [1:0]         req_type;
  logic [FIELD_W-1:0] key;
  logic [FIELD_W-1:0] value;
  logic               result_strobe;
  logic               status;
  logic               found;
  logic [FIELD_W-1:0] read_value;
  logic               released_valid;
  logic [FIELD_W-1:0] released_value;
  logic [COUNT_W-1:0] entry_count;
  logic               last;

  // Shadow copy of the table
  bit                 release_on;
  bit                 slot_used [ENTRIES];
  logic [FIELD_W-1:0] slot_k [ENTRIES];
  logic [FIELD_W-1:0] slot_v [ENTRIES];
  int unsigned        slot_age [ENTRIES];
  int unsigned        held;

  map_resp_t          awaited_responses [$];
  logic [FIELD_W-1:0] key_pool [KEY_POOL];

  int                 errors = 0;
  int                 cycle_count = 0;
  int                 req_count [4];
  int                 responses_checked = 0;
  int                 releases_seen = 0;
  int                 refusals_seen = 0;

  key_value_map_table_core #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (FIELD_W),
    .VALUE_BITS (FIELD_W)
  ) u_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .req_type       (req_type),
    .key            (key),
    .value          (value),
    .result_strobe  (result_strobe),
    .status         (status),
    .found          (found),
    .read_value     (read_value),
    .released_valid (released_valid),
    .released_value (released_value),
    .entry_count    (entry_count),
    .last           (last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d responses outstanding",
               $time, cycle_count, awaited_responses.size());
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int find_slot(input logic [FIELD_W-1:0] k);
    for (int i = 0; i < ENTRIES; i++)
      if (slot_used[i] && slot_k[i] == k)
        return i;
    return -1;
  endfunction

  function automatic map_resp_t make_resp(input logic st, input logic fd,
                                          input logic [FIELD_W-1:0] rd,
                                          input logic rv,
                                          input logic [FIELD_W-1:0] rel,
                                          input logic lst);
    map_resp_t r;
    r.status         = st;
    r.found          = fd;
    r.read_value     = rd;
    r.released_valid = rv;
    r.released_value = rel;
    r.entry_count    = held[COUNT_W-1:0];
    r.last           = lst;
    return r;
  endfunction

  // Apply one request to the shadow table and queue the responses it causes
  task automatic apply_to_shadow(input req_t rt, input logic [FIELD_W-1:0] k,
                                 input logic [FIELD_W-1:0] v);
    int                 idx;
    int unsigned        rank;
    bit                 rel;
    logic [FIELD_W-1:0] old;
    logic [FIELD_W-1:0] dropped [$];
    idx = find_slot(k);
    case (rt)
      REQ_SET: begin
        if (idx >= 0) begin
          old = slot_v[idx];
          rel = release_on && old != '0 && old != v;
          slot_v[idx] = v;
          awaited_responses.push_back(make_resp(1'b0, 1'b1, '0, rel, rel ? old : '0, 1'b1));
        end else if (held >= ENTRIES) begin
          awaited_responses.push_back(make_resp(1'b1, 1'b0, '0, 1'b0, '0, 1'b1));
        end else begin
          for (int i = 0; i < ENTRIES; i++)
            if (slot_used[i])
              slot_age[i]++;
          for (int i = 0; i < ENTRIES; i++) begin
            if (!slot_used[i]) begin
              slot_used[i] = 1'b1;
              slot_k[i]    = k;
              slot_v[i]    = v;
              slot_age[i]  = 0;
              break;
            end
          end
          held++;
          awaited_responses.push_back(make_resp(1'b0, 1'b0, '0, 1'b0, '0, 1'b1));
        end
      end
      REQ_LOOKUP: begin
        if (idx >= 0)
          awaited_responses.push_back(make_resp(1'b0, 1'b1, slot_v[idx], 1'b0, '0, 1'b1));
        else
          awaited_responses.push_back(make_resp(1'b0, 1'b0, '0, 1'b0, '0, 1'b1));
      end
      REQ_REMOVE: begin
        if (idx < 0) begin
          awaited_responses.push_back(make_resp(1'b0, 1'b0, '0, 1'b0, '0, 1'b1));
        end else begin
          rank = slot_age[idx];
          slot_used[idx] = 1'b0;
          for (int i = 0; i < ENTRIES; i++)
            if (slot_used[i] && slot_age[i] > rank)
              slot_age[i]--;
          held--;
          awaited_responses.push_back(make_resp(1'b0, 1'b1, slot_v[idx], 1'b0, '0, 1'b1));
        end
      end
      default: begin
        // Collect nonzero values newest first, skipping zero values
        if (release_on) begin
          for (int unsigned r = 0; r < held; r++) begin
            for (int i = 0; i < ENTRIES; i++) begin
              if (slot_used[i] && slot_age[i] == r) begin
                if (slot_v[i] != '0)
                  dropped.push_back(slot_v[i]);
                break;
              end
            end
          end
        end
        for (int i = 0; i < ENTRIES; i++)
          slot_used[i] = 1'b0;
        held = 0;
        if (dropped.size() == 0)
          awaited_responses.push_back(make_resp(1'b0, 1'b0, '0, 1'b0, '0, 1'b1));
        else
          foreach (dropped[i])
            awaited_responses.push_back(make_resp(1'b0, 1'b0, '0, 1'b1, dropped[i],
                                                  i == dropped.size() - 1));
      end
    endcase
  endtask

  task automatic compare_field(input string fname, input logic [FIELD_W-1:0] want,
                               input logic [FIELD_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
    end
  endtask

  task automatic check_response();
    map_resp_t want;
    if (awaited_responses.size() == 0) begin
      errors++;
      $display("%0t: result strobe mismatch, expected no result, actual count %0d",
               $time, entry_count);
    end else begin
      want = awaited_responses.pop_front();
      compare_field("status", want.status, status);
      compare_field("found", want.found, found);
      compare_field("read_value", want.read_value, read_value);
      compare_field("released_valid", want.released_valid, released_valid);
      compare_field("released_value", want.released_value, released_value);
      compare_field("entry_count", want.entry_count, entry_count);
      compare_field("last", want.last, last);
    end
    responses_checked++;
    if (released_valid === 1'b1)
      releases_seen++;
    if (status === 1'b1)
      refusals_seen++;
  endtask

  always @(posedge clk) begin
    if (!rst && result_strobe)
      check_response();
  end

  // Present one request and hold it until the core takes it
  task automatic send_request(input req_t rt, input logic [FIELD_W-1:0] k,
                              input logic [FIELD_W-1:0] v);
    @(negedge clk);
    start    <= 1'b1;
    req_type <= rt;
    key      <= k;
    value    <= v;
    @(posedge clk);
    while (busy)
      @(posedge clk);
    apply_to_shadow(rt, k, v);
    req_count[rt]++;
    @(negedge clk);
    start <= 1'b0;
  endtask

  task automatic wait_idle();
    while (awaited_responses.size() != 0)
      @(posedge clk);
    @(posedge clk);
    while (busy)
      @(posedge clk);
    // Idle on after the rank pass, which busy already covers, before touching the register
    repeat (ENTRIES + 2) @(posedge clk);
  endtask

  task automatic write_release_enable(input bit en);
    wait_idle();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= en;
    @(negedge clk);
    cfg_write <= 1'b0;
    release_on = en;
  endtask

  task automatic test_basic_ops();
    write_release_enable(1'b0);
    send_request(REQ_LOOKUP, '0, '1);
    send_request(REQ_SET, '0, '0);
    send_request(REQ_LOOKUP, '0, '0);
    send_request(REQ_SET, '1, '1);
    send_request(REQ_SET, '1, 64'd5);
    send_request(REQ_REMOVE, 64'h5555_5555_aaaa_aaaa, '0);
    send_request(REQ_REMOVE, '0, '1);
  endtask

  task automatic test_overwrite_release();
    write_release_enable(1'b1);
    send_request(REQ_SET, '1, 64'd5);
    send_request(REQ_SET, '1, '0);
    send_request(REQ_SET, '1, 64'd9);
    send_request(REQ_SET, '1, '1);
  endtask

  task automatic test_table_full();
    logic [FIELD_W-1:0] k;
    int                 n;
    n = 0;
    while (held < ENTRIES) begin
      k = {$urandom, $urandom};
      if (find_slot(k) < 0) begin
        send_request(REQ_SET, k, (n % 4 == 1) ? '0 : {$urandom, $urandom});
        n++;
      end
    end
    k = {$urandom, $urandom};
    while (find_slot(k) >= 0)
      k = {$urandom, $urandom};
    send_request(REQ_SET, k, {$urandom, $urandom});
    send_request(REQ_SET, '1, 64'h0123_4567_89ab_cdef);
    send_request(REQ_CLEAR, '0, '0);
    send_request(REQ_CLEAR, '1, '1);
  endtask

  task automatic run_random(input int n_items, input int clear_pct, input bit gaps);
    int                 pick;
    int                 idx;
    req_t               rt;
    logic [FIELD_W-1:0] k;
    logic [FIELD_W-1:0] v;
    for (int j = 0; j < n_items; j++) begin
      if (gaps && $urandom_range(0, 2) == 0) begin
        // Land the gap either while busy or after the core went idle
        if ($urandom_range(0, 1) == 1) begin
          @(posedge clk);
          while (busy)
            @(posedge clk);
        end
        repeat ($urandom_range(1, 11)) @(negedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick < clear_pct)
        rt = REQ_CLEAR;
      else if (pick < clear_pct + 45)
        rt = REQ_SET;
      else if (pick < clear_pct + 70)
        rt = REQ_LOOKUP;
      else
        rt = REQ_REMOVE;
      if ($urandom_range(0, 6) == 0)
        k = {$urandom, $urandom};
      else
        k = key_pool[$urandom_range(0, KEY_POOL - 1)];
      idx = find_slot(k);
      case ($urandom_range(0, 9))
        0, 1:    v = '0;
        2:       v = (idx >= 0) ? slot_v[idx] : '1;
        default: v = {$urandom, $urandom};
      endcase
      send_request(rt, k, v);
      // Halfway through a run with gaps, hold off until every pending result has come back
      if (gaps && j == n_items / 2)
        wait_idle();
    end
  endtask

  task automatic test_random_release_on();
    write_release_enable(1'b1);
    run_random(35, 3, 1'b1);
  endtask

  task automatic test_random_release_off();
    write_release_enable(1'b0);
    run_random(30, 10, 1'b1);
  endtask

  task automatic test_random_back_to_back();
    write_release_enable(1'b1);
    run_random(35, 6, 1'b0);
  endtask

  initial begin
    rst       = 1'b1;
    start     = 1'b0;
    cfg_write = 1'b0;
    cfg_data  = 1'b0;
    req_type  = REQ_SET;
    key       = '0;
    value     = '0;
    release_on = 1'b0;
    held       = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      slot_used[i] = 1'b0;
      slot_k[i]    = '0;
      slot_v[i]    = '0;
      slot_age[i]  = 0;
    end
    for (int i = 0; i < 4; i++)
      req_count[i] = 0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL; i++)
      key_pool[i] = {$urandom, $urandom};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_basic_ops();
    test_overwrite_release();
    test_table_full();
    test_random_release_on();
    test_random_release_off();
    test_random_back_to_back();

    while (awaited_responses.size() != 0)
      @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (awaited_responses.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, awaited_responses.size());
    end

    $display("Ran %0d set, %0d lookup, %0d remove, %0d clear requests with release on/off.",
             req_count[REQ_SET], req_count[REQ_LOOKUP], req_count[REQ_REMOVE],
             req_count[REQ_CLEAR]);
    $display("Checked %0d results: %0d releases, %0d refused sets, %0d errors.",
             responses_checked, releases_seen, refusals_seen, errors);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
